>>> sv/four_wire_nibble_frame_tx_macros.svh
// Assertion macros shared by the nibble frame transmitter.
`ifndef FOUR_WIRE_NIBBLE_FRAME_TX_MACROS_SVH
`define FOUR_WIRE_NIBBLE_FRAME_TX_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FWNF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fwnf assertion failed");

// Next-cycle implication, disabled during reset.
`define FWNF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fwnf assertion failed");

`endif

>>> sv/fwnf_pkg.sv
package fwnf_pkg;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_FRAME_PERIOD    = 3'd0,
      REG_DATA_BYTE_ZERO  = 3'd1,
      REG_DATA_BYTE_ONE   = 3'd2,
      REG_DATA_BYTE_TWO   = 3'd3,
      REG_DATA_BYTE_THREE = 3'd4
   } csr_index_type;

   localparam logic [14:0] PERIOD_RESET = 15'd500;
   localparam logic [7:0]  BYTE_ZERO_RESET = 8'd229;
   localparam logic [7:0]  BYTE_ONE_RESET = 8'd193;
   localparam logic [7:0]  BYTE_TWO_RESET = 8'd229;
   localparam logic [7:0]  BYTE_THREE_RESET = 8'd245;

   // Countdown values that bound the frame and its start field.
   localparam logic [14:0] FRAME_SLOTS = 15'd14;
   localparam logic [14:0] START_SLOTS_LOW = 15'd9;
   localparam logic [14:0] DATA_SLOTS = 15'd8;

   localparam logic [3:0] ALL_HIGH = 4'hF;
   localparam logic [3:0] ALL_LOW = 4'h0;

   // Configuration as seen by the frame engine.
   typedef struct packed {
      logic [14:0]     frame_period;
      logic [3:0][7:0] data_bytes;
   } cfg_type;

   // One result.
   typedef struct packed {
      logic [3:0] line_pins;
      logic       frame_end;
      logic [2:0] nibble_slot;
   } rsp_type;

endpackage

>>> sv/four_wire_nibble_frame_tx.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_tick
// rsp       out        rsp_valid/rsp_ready    rsp_line_pins, rsp_frame_end, rsp_nibble_slot
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// Every request produces one response in the cycle after it is accepted; the
// frame state and the result register update in the same cycle.
// One request per cycle is sustained while rsp_ready is high; the result register sets the rate.
// Reset clears the countdown, nibble position, lines and result valid, and
// loads the register defaults. csr_ready is always high.
// A stalled response holds req_ready low until rsp_ready returns.
`include "four_wire_nibble_frame_tx_macros.svh"

module four_wire_nibble_frame_tx
   import fwnf_pkg::*;
#(
   parameter int unsigned NUM_BYTES = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_tick,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_line_pins,
   output logic        rsp_frame_end,
   output logic [2:0]  rsp_nibble_slot,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [14:0] csr_data
);

   // Highest nibble position for the configured byte count.
   localparam logic [2:0] LAST_SLOT = 3'(2 * NUM_BYTES - 1);

   cfg_type cfg;
   rsp_type result;
   rsp_type rsp_data;
   logic    accept;
   logic    hold_accept;

   fwnf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   fwnf_engine #(
      .NUM_BYTES (NUM_BYTES)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .tick   (req_tick),
      .cfg    (cfg),
      .result (result)
   );

   fwnf_out u_out (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .accept    (accept),
      .result    (result),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_line_pins = rsp_data.line_pins;
   assign rsp_frame_end = rsp_data.frame_end;
   assign rsp_nibble_slot = rsp_data.nibble_slot;

   // An accepted request that carries no tick.
   assign hold_accept = accept && !req_tick;

   // A frame always ends with all lines low.
   `FWNF_ASSERT_NOW(a_end_lines_low, clock, reset, rsp_valid && rsp_frame_end, rsp_line_pins == 4'h0)
   // Requests are refused only while a response is stalled.
   `FWNF_ASSERT_NOW(a_ready_stall, clock, reset, !req_ready, rsp_valid && !rsp_ready)
   // A hold request never ends a frame.
   `FWNF_ASSERT_NEXT(a_hold_no_end, clock, reset, hold_accept, rsp_valid && !rsp_frame_end)
   // The nibble position stays within the configured bytes.
   `FWNF_ASSERT_NOW(a_slot_range, clock, reset, rsp_valid, rsp_nibble_slot <= LAST_SLOT)

endmodule

>>> sv/fwnf_csr.sv
module fwnf_csr
   import fwnf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [14:0] csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   // Register decode; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_FRAME_PERIOD:    cfg_in.frame_period = csr_data;
            REG_DATA_BYTE_ZERO:  cfg_in.data_bytes[0] = csr_data[7:0];
            REG_DATA_BYTE_ONE:   cfg_in.data_bytes[1] = csr_data[7:0];
            REG_DATA_BYTE_TWO:   cfg_in.data_bytes[2] = csr_data[7:0];
            REG_DATA_BYTE_THREE: cfg_in.data_bytes[3] = csr_data[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_period <= PERIOD_RESET;
         cfg_ff.data_bytes[0] <= BYTE_ZERO_RESET;
         cfg_ff.data_bytes[1] <= BYTE_ONE_RESET;
         cfg_ff.data_bytes[2] <= BYTE_TWO_RESET;
         cfg_ff.data_bytes[3] <= BYTE_THREE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/fwnf_engine.sv
module fwnf_engine
   import fwnf_pkg::*;
#(
   parameter int unsigned NUM_BYTES = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  logic    tick,
   input  cfg_type cfg,
   output rsp_type result
);

   logic [14:0] countdown_ff;
   logic [14:0] countdown_in;
   logic [2:0]  position_ff;
   logic [2:0]  position_in;
   logic [3:0]  lines_ff;
   logic [3:0]  lines_in;
   logic        frame_end;

   logic [7:0]  cur_byte;
   logic [3:0]  nibble;
   logic [14:0] count_dec;
   logic [3:0]  count_less;
   logic [1:0]  line_idx;
   logic [3:0]  line_mask;
   logic        data_bit;

   // Current nibble: even positions send the high half.
   assign cur_byte = cfg.data_bytes[position_ff[2:1]];
   assign nibble = position_ff[0] ? cur_byte[3:0] : cur_byte[7:4];

   // Data slot pairs map countdown 8,7 to line 4 down to 2,1 to line 1.
   assign count_dec = countdown_ff - 15'd1;
   assign count_less = count_dec[3:0] - 4'd1;
   assign line_idx = count_less[2:1];
   assign line_mask = 4'b0001 << line_idx;
   assign data_bit = nibble[line_idx];

   // Next state for one accepted request.
   always_comb begin
      countdown_in = countdown_ff;
      position_in = position_ff;
      lines_in = lines_ff;
      frame_end = 1'b0;
      if (tick) begin
         if (countdown_ff == 15'd0) begin
            countdown_in = cfg.frame_period;
            lines_in = ALL_LOW;
         end else if (count_dec == 15'd0) begin
            frame_end = 1'b1;
            position_in = (position_ff == 3'(2 * NUM_BYTES - 1)) ? 3'd0 :
                          position_ff + 3'd1;
            countdown_in = cfg.frame_period;
            lines_in = ALL_LOW;
         end else begin
            countdown_in = count_dec;
            if (count_dec > START_SLOTS_LOW && count_dec <= FRAME_SLOTS) begin
               lines_in = ALL_HIGH;
            end else if (count_dec == START_SLOTS_LOW) begin
               lines_in = ALL_LOW;
            end else if (count_dec <= DATA_SLOTS) begin
               // The first slot of a pair starts from all lines low.
               if (!count_dec[0]) begin
                  lines_in = data_bit ? line_mask : ALL_LOW;
               end else if (data_bit) begin
                  lines_in = lines_ff | line_mask;
               end else begin
                  lines_in = lines_ff & ~line_mask;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= 15'd0;
         position_ff <= 3'd0;
         lines_ff <= ALL_LOW;
      end else if (accept) begin
         countdown_ff <= countdown_in;
         position_ff <= position_in;
         lines_ff <= lines_in;
      end
   end

   assign result.line_pins = lines_in;
   assign result.frame_end = frame_end;
   assign result.nibble_slot = position_in;

endmodule

>>> sv/fwnf_out.sv
module fwnf_out
   import fwnf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    accept,
   input  rsp_type result,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // A new request enters whenever the result register drains or is empty.
   assign req_ready = !valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import fwnf_pkg::*;

   localparam int NUM_BYTES = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES = 12;
   localparam int TICKS_PER_PHASE = 40;
   localparam int PAUSE_PHASE = 5;
   localparam int MAX_IDLE = 8;
   localparam int DRAIN_CYCLES = 4;

   // Register indexes that the block does not decode.
   localparam logic [2:0] REG_UNMAPPED = 3'd5;
   localparam logic [2:0] REG_INDEX_MAX = 3'd7;

   // Start field of a frame: five slots high, then one slot low.
   localparam logic [5:0] START_FIELD = 6'b011111;

   // One row of the directed table: a register write or a tick request.
   typedef struct packed {
      logic        is_cfg;
      logic [2:0]  index;
      logic [14:0] data;
      logic        tick;
      logic        typed;
      logic [3:0]  pins;
      logic        frame_end;
      logic [2:0]  slot;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 23;

   // Period 15 and byte zero 0xA5 give one whole frame: start field, then
   // the high nibble 1010 on lines 4, 3, 2 and 1.
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{1'b1, REG_UNMAPPED,       15'h7FFF, 1'b0, 1'b0, ALL_LOW,  1'b0, 3'd0},
      '{1'b1, REG_FRAME_PERIOD,   15'd15,   1'b0, 1'b0, ALL_LOW,  1'b0, 3'd0},
      '{1'b1, REG_DATA_BYTE_ZERO, 15'h00A5, 1'b0, 1'b0, ALL_LOW,  1'b0, 3'd0},
      '{1'b0, '0,                 '0,       1'b0, 1'b1, ALL_LOW,  1'b0, 3'd0},
      '{1'b0, '0,                 '0,       1'b1, 1'b1, ALL_LOW,  1'b0, 3'd0},
      '{1'b0, '0,                 '0,       1'b1, 1'b1, ALL_HIGH, 1'b0, 3'd0},
      '{1'b0, '0,                 '0,       1'b1, 1'b1, ALL_HIGH, 1'b0, 3'd0},
      '{1'b0, '0,                 '0,       1'b1, 1'b1, ALL_HIGH, 1'b0, 3'd0},
      '{1'b0, '0,                 '0,       1'b1, 1'b1, ALL_HIGH, 1'b0, 3'd0},
      '{1'b0, '0,                 '0,       1'b1, 1'b1, ALL_HIGH, 1'b0, 3'd0},
      '{1'b0, '0,                 '0,       1'b1, 1'b1, ALL_LOW,  1'b0, 3'd0},
      '{1'b0, '0,                 '0,       1'b1, 1'b1, 4'h8,     1'b0, 3'd0},
      '{1'b0, '0,                 '0,       1'b0, 1'b1, 4'h8,     1'b0, 3'd0},
      '{1'b0, '0,                 '0,       1'b1, 1'b1, 4'h8,     1'b0, 3'd0},
      '{1'b0, '0,                 '0,       1'b1, 1'b1, ALL_LOW,  1'b0, 3'd0},
      '{1'b0, '0,                 '0,       1'b1, 1'b1, ALL_LOW,  1'b0, 3'd0},
      '{1'b0, '0,                 '0,       1'b1, 1'b1, 4'h2,     1'b0, 3'd0},
      '{1'b0, '0,                 '0,       1'b1, 1'b1, 4'h2,     1'b0, 3'd0},
      '{1'b0, '0,                 '0,       1'b1, 1'b1, ALL_LOW,  1'b0, 3'd0},
      '{1'b0, '0,                 '0,       1'b1, 1'b1, ALL_LOW,  1'b0, 3'd0},
      '{1'b0, '0,                 '0,       1'b1, 1'b1, ALL_LOW,  1'b1, 3'd1},
      '{1'b0, '0,                 '0,       1'b1, 1'b0, ALL_LOW,  1'b0, 3'd0},
      '{1'b0, '0,                 '0,       1'b0, 1'b0, ALL_LOW,  1'b0, 3'd0}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_tick = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_line_pins;
   logic        rsp_frame_end;
   logic [2:0]  rsp_nibble_slot;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [14:0] csr_data = '0;

   // Shadow of the transmitter: configuration and frame state.
   logic [14:0] cfg_period;
   logic [7:0]  cfg_bytes [NUM_BYTES];
   logic [15:0] shadow_countdown;
   logic [2:0]  shadow_nibble;
   logic [3:0]  shadow_levels;

   rsp_type     awaited_lines [$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          no_idle = 1'b0;

   four_wire_nibble_frame_tx dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_tick        (req_tick),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_line_pins   (rsp_line_pins),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_nibble_slot (rsp_nibble_slot),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Advances the shadow state by one tick request and returns the line state.
   function automatic rsp_type advance_line_state(input logic tick);
      rsp_type     lines;
      logic [7:0]  cur_byte;
      logic [3:0]  nib;
      logic [13:0] word;
      int          slot;
      int          line_num;
      logic [3:0]  mask;
      lines.frame_end = 1'b0;
      if (tick) begin
         cur_byte = cfg_bytes[shadow_nibble[2:1]];
         nib = shadow_nibble[0] ? cur_byte[3:0] : cur_byte[7:4];
         // Slot k of the frame is bit k; each nibble bit fills two slots, MSB first.
         word = {nib[0], nib[0], nib[1], nib[1], nib[2], nib[2], nib[3], nib[3],
                 START_FIELD};
         if (shadow_countdown == 0) begin
            shadow_countdown = {1'b0, cfg_period};
            shadow_levels = ALL_LOW;
         end else begin
            shadow_countdown = shadow_countdown - 1'b1;
            if (shadow_countdown >= 1 && shadow_countdown <= FRAME_SLOTS) begin
               slot = int'(FRAME_SLOTS) - int'(shadow_countdown);
               if (shadow_countdown >= START_SLOTS_LOW) begin
                  shadow_levels = word[slot] ? ALL_HIGH : ALL_LOW;
               end else begin
                  // Data slots: line 4 down to line 1, two slots each.
                  line_num = (int'(shadow_countdown) + 1) / 2;
                  mask = 4'b0001 << (line_num - 1);
                  if (slot % 2 == 0) begin
                     shadow_levels = ALL_LOW;
                  end
                  shadow_levels = word[slot] ? (shadow_levels | mask)
                                             : (shadow_levels & ~mask);
               end
            end
            if (shadow_countdown == 0) begin
               lines.frame_end = 1'b1;
               if (shadow_nibble == 3'(2 * NUM_BYTES - 1)) begin
                  shadow_nibble = '0;
               end else begin
                  shadow_nibble = shadow_nibble + 1'b1;
               end
               shadow_countdown = {1'b0, cfg_period};
               shadow_levels = ALL_LOW;
            end
         end
      end
      lines.line_pins = shadow_levels;
      lines.nibble_slot = shadow_nibble;
      return lines;
   endfunction

   task automatic report_mismatch(input string field, input int unsigned want,
                                  input int unsigned got);
      $display("ERROR at cycle %0d: %s expected %0h, observed %0h",
               cycle_count, field, want, got);
      error_count++;
   endtask

   // Sends one tick request after a random gap and records its outcome.
   task automatic send_tick(input logic tick, input logic typed, input rsp_type typed_lines);
      int      gap;
      rsp_type lines;
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      csr_valid <= 1'b0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_tick <= tick;
      do @(posedge clock); while (!req_ready);
      lines = advance_line_state(tick);
      awaited_lines.push_back(typed ? typed_lines : lines);
   endtask

   // Stops requests and register writes and waits until every pending
   // response has come back.
   task automatic wait_lines_drained();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      do @(posedge clock); while (awaited_lines.size() != 0);
   endtask

   // Writes one register; csr_valid is lowered by the next tick request or drain.
   task automatic write_csr(input logic [2:0] index, input logic [14:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         REG_FRAME_PERIOD:    cfg_period = data;
         REG_DATA_BYTE_ZERO:  cfg_bytes[0] = data[7:0];
         REG_DATA_BYTE_ONE:   cfg_bytes[1] = data[7:0];
         REG_DATA_BYTE_TWO:   cfg_bytes[2] = data[7:0];
         REG_DATA_BYTE_THREE: cfg_bytes[3] = data[7:0];
         default: ;
      endcase
   endtask

   // Response side: random stalls, then compare with the oldest pending entry.
   initial begin
      int      stall;
      rsp_type want;
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (awaited_lines.size() == 0) begin
            $display("ERROR at cycle %0d: response with no request pending", cycle_count);
            error_count++;
         end else begin
            want = awaited_lines.pop_front();
            if (rsp_line_pins !== want.line_pins) begin
               report_mismatch("line_pins", want.line_pins, rsp_line_pins);
            end
            if (rsp_frame_end !== want.frame_end) begin
               report_mismatch("frame_end", want.frame_end, rsp_frame_end);
            end
            if (rsp_nibble_slot !== want.nibble_slot) begin
               report_mismatch("nibble_slot", want.nibble_slot, rsp_nibble_slot);
            end
         end
      end
   end

   // Main sequence: reset, directed table, then random configuration phases.
   initial begin
      stim_row_type row;
      rsp_type      typed_lines;
      logic [14:0]  period;
      logic [14:0]  value;
      logic         tick;

      cfg_period = PERIOD_RESET;
      cfg_bytes[0] = BYTE_ZERO_RESET;
      cfg_bytes[1] = BYTE_ONE_RESET;
      cfg_bytes[2] = BYTE_TWO_RESET;
      cfg_bytes[3] = BYTE_THREE_RESET;
      shadow_countdown = '0;
      shadow_nibble = '0;
      shadow_levels = ALL_LOW;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table.
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row = DIRECTED[r];
         if (row.is_cfg) begin
            wait_lines_drained();
            write_csr(row.index, row.data);
         end else begin
            typed_lines.line_pins = row.pins;
            typed_lines.frame_end = row.frame_end;
            typed_lines.nibble_slot = row.slot;
            send_tick(row.tick, row.typed, typed_lines);
         end
      end

      // Random phases; the largest period comes last since it only reloads at zero.
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_lines_drained();
         no_idle = ($urandom_range(0, 3) == 0);
         if (phase == PHASES - 1) begin
            period = 15'h7FFF;
         end else if (phase == 1) begin
            period = '0;
         end else if (phase == 2) begin
            period = 15'd1;
         end else if (phase == 3) begin
            period = FRAME_SLOTS;
         end else if (phase == 4) begin
            period = FRAME_SLOTS + 1'b1;
         end else if ($urandom_range(0, 4) == 0) begin
            period = 15'($urandom_range(2, 13));
         end else begin
            period = 15'($urandom_range(15, 40));
         end
         write_csr(REG_FRAME_PERIOD, period);
         for (int k = REG_DATA_BYTE_ZERO; k <= REG_DATA_BYTE_THREE; k++) begin
            if (phase == 0 || $urandom_range(0, 3) != 0) begin
               case ($urandom_range(0, 3))
                  0: value = '0;
                  1: value = 15'h00FF;
                  2: value = 15'h7FFF;
                  default: value = 15'($urandom_range(0, 15'h7FFF));
               endcase
               write_csr(3'(k), value);
            end
         end
         if ($urandom_range(0, 3) == 0) begin
            write_csr(3'($urandom_range(REG_UNMAPPED, REG_INDEX_MAX)),
                      15'($urandom_range(0, 15'h7FFF)));
         end
         for (int i = 0; i < TICKS_PER_PHASE; i++) begin
            tick = ($urandom_range(0, 99) < 85);
            send_tick(tick, 1'b0, '0);
            // Hold off new requests until the pipeline is empty.
            if (phase == PAUSE_PHASE && i == TICKS_PER_PHASE / 2) begin
               wait_lines_drained();
            end
         end
      end

      wait_lines_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_lines.size() != 0) begin
         $display("ERROR: %0d responses never arrived", awaited_lines.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> four_wire_nibble_frame_tx.f
+incdir+sv
sv/fwnf_pkg.sv
sv/fwnf_csr.sv
sv/fwnf_engine.sv
sv/fwnf_out.sv
sv/four_wire_nibble_frame_tx.sv
verif/tb.sv
